@@ src/mi3_pkg.sv @@
package mi3_pkg;

  localparam int NUM_ELEM = 9;

  typedef logic [3:0] idx_t;

  // operand indices for cofactor k = a[i0]*a[i1] - a[i2]*a[i3], row-major
  localparam idx_t COF_IDX [NUM_ELEM][4] = '{
    '{4'd4, 4'd8, 4'd7, 4'd5},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd6, 4'd4},
    '{4'd6, 4'd1, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd3, 4'd1}
  };

  localparam idx_t FIRST_IDX = 4'd0;
  localparam idx_t LAST_IDX  = 4'd8;

endpackage

@@ src/mi3_queue.sv @@
module mi3_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];

endmodule

@@ src/mi3_front.sv @@
module mi3_front #(
  parameter int ELEM_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [9*ELEM_WIDTH-1:0]               in_data_i,
  output logic                                  push_o,
  input  logic                                  full_i,
  output logic [9*(2*ELEM_WIDTH+1)-1:0]         cof_o,
  output logic [3*ELEM_WIDTH+1:0]               det_o
);

  localparam int W  = ELEM_WIDTH;
  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 2;

  localparam logic [4:0] STEP_COF_LAST = 5'd8;
  localparam logic [4:0] STEP_COF_WB   = 5'd9;
  localparam logic [4:0] STEP_DET0     = 5'd10;
  localparam logic [4:0] STEP_DET2     = 5'd12;
  localparam logic [4:0] STEP_ACC0     = 5'd11;
  localparam logic [4:0] STEP_ACC2     = 5'd13;
  localparam logic [4:0] STEP_PUSH     = 5'd14;

  logic signed [W-1:0]    mat_q [9];
  logic signed [CW-1:0]   cof_q [9];
  logic signed [2*W-1:0]  m1_q, m2_q;
  logic signed [2*W:0]    phi_q, plo_q;
  logic signed [DW-1:0]   acc_q;
  logic                   busy_q;
  logic [4:0]             cnt_q;

  mi3_pkg::idx_t          csel, wsel;
  logic [1:0]             dsel;
  logic signed [CW-1:0]   dcof;
  logic signed [W-1:0]    dmat;
  logic signed [DW-1:0]   term;

  always_comb begin
    csel = (cnt_q <= STEP_COF_LAST) ? cnt_q[3:0] : mi3_pkg::FIRST_IDX;
    wsel = cnt_q[3:0] - 4'd1;
    dsel = 2'(cnt_q - STEP_DET0);
    case (dsel)
      2'd1:    dcof = cof_q[3];
      2'd2:    dcof = cof_q[6];
      default: dcof = cof_q[0];
    endcase
    dmat = mat_q[{2'b00, dsel}];
    term = (DW'(phi_q) <<< W) + DW'(plo_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else if (!busy_q) begin
      if (in_valid_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
      end
    end else if (cnt_q == STEP_PUSH) begin
      if (!full_i) begin
        busy_q <= 1'b0;
      end
    end else begin
      cnt_q <= cnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && in_valid_i) begin
      for (int i = 0; i < 9; i++) begin
        mat_q[i] <= $signed(in_data_i[i*W +: W]);
      end
    end
    if (busy_q) begin
      if (cnt_q <= STEP_COF_LAST) begin
        m1_q <= mat_q[mi3_pkg::COF_IDX[csel][0]] * mat_q[mi3_pkg::COF_IDX[csel][1]];
        m2_q <= mat_q[mi3_pkg::COF_IDX[csel][2]] * mat_q[mi3_pkg::COF_IDX[csel][3]];
      end
      if (cnt_q != 5'd0 && cnt_q <= STEP_COF_WB) begin
        cof_q[wsel] <= CW'(m1_q) - CW'(m2_q);
      end
      if (cnt_q >= STEP_DET0 && cnt_q <= STEP_DET2) begin
        phi_q <= dmat * $signed(dcof[CW-1:W]);
        plo_q <= dmat * $signed({1'b0, dcof[W-1:0]});
      end
      if (cnt_q == STEP_ACC0) begin
        acc_q <= term;
      end else if (cnt_q > STEP_ACC0 && cnt_q <= STEP_ACC2) begin
        acc_q <= acc_q + term;
      end
    end
  end

  assign in_ready_o = !busy_q;
  assign push_o     = busy_q && (cnt_q == STEP_PUSH) && !full_i;
  assign det_o      = acc_q;

  for (genvar g = 0; g < 9; g++) begin : g_cof
    assign cof_o[g*CW +: CW] = cof_q[g];
  end

endmodule

@@ src/mi3_back.sv @@
module mi3_back #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_valid_i,
  input  logic [9*(2*ELEM_WIDTH+1)+3*ELEM_WIDTH+1:0] q_data_i,
  output logic                                  pop_o,
  output logic                                  m_valid_o,
  input  logic                                  m_ready_i,
  output logic [9*ELEM_WIDTH-1:0]               elem_o,
  output logic [ELEM_WIDTH-1:0]                 det_o,
  output logic                                  singular_o,
  output logic                                  overflow_o
);

  localparam int W  = ELEM_WIDTH;
  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 2;
  localparam int QB = W + 1;
  localparam int NW = CW + 2 * FRAC_BITS;
  localparam int HW = NW - QB;
  localparam int XW = HW + DW;

  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  // divider pipe
  logic          pv_q   [QB+1];
  logic [DW-1:0] r_q    [QB+1];
  logic [QB-1:0] n_q    [QB+1];
  logic [QB-1:0] qb_q   [QB+1];
  logic [DW-1:0] d_q    [QB+1];
  logic          neg_q  [QB+1];
  logic          sat_q  [QB+1];
  logic          sing_q [QB+1];
  logic          last_q [QB+1];
  mi3_pkg::idx_t kk_q   [QB+1];
  logic [W-1:0]  dv_q   [QB+1];
  logic          dovf_q [QB+1];

  mi3_pkg::idx_t k_q;
  logic          en, issue;

  logic [CW-1:0] cof, cmag;
  logic [DW-1:0] det, dmag, dsh, lim;
  logic [NW-1:0] nfull;
  logic [HW-1:0] hi;
  logic          cneg, dneg, presat, dsing, det_ovf;
  logic [W-1:0]  det_val;

  always_comb begin
    cof    = q_data_i[k_q*CW +: CW];
    det    = q_data_i[9*CW +: DW];
    cneg   = cof[CW-1];
    cmag   = cneg ? -cof : cof;
    dneg   = det[DW-1];
    dmag   = dneg ? -det : det;
    nfull  = {cmag, {(2*FRAC_BITS){1'b0}}};
    hi     = nfull[NW-1:QB];
    dsing  = dmag == '0;
    presat = XW'(hi) >= XW'(dmag);
    lim    = DW'(1) << (W - 1);
    dsh    = dmag >> (2 * FRAC_BITS);
    det_ovf = 1'b0;
    if (!dneg && dsh >= lim) begin
      det_val = VMAX;
      det_ovf = 1'b1;
    end else if (dneg && dsh > lim) begin
      det_val = VMIN;
      det_ovf = 1'b1;
    end else begin
      det_val = dneg ? -dsh[W-1:0] : dsh[W-1:0];
    end
  end

  logic out_valid_q;
  assign en    = !out_valid_q || m_ready_i;
  assign issue = q_valid_i && en;
  assign pop_o = issue && (k_q == mi3_pkg::LAST_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= mi3_pkg::FIRST_IDX;
      for (int i = 0; i <= QB; i++) begin
        pv_q[i] <= 1'b0;
      end
    end else if (en) begin
      if (issue) begin
        k_q <= (k_q == mi3_pkg::LAST_IDX) ? mi3_pkg::FIRST_IDX : k_q + 4'd1;
      end
      pv_q[0] <= issue;
      for (int i = 0; i < QB; i++) begin
        pv_q[i+1] <= pv_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q[0]    <= presat ? '0 : DW'(hi);
      n_q[0]    <= nfull[QB-1:0];
      qb_q[0]   <= '0;
      d_q[0]    <= dmag;
      neg_q[0]  <= cneg ^ dneg;
      sat_q[0]  <= presat;
      sing_q[0] <= dsing;
      last_q[0] <= k_q == mi3_pkg::LAST_IDX;
      kk_q[0]   <= k_q;
      dv_q[0]   <= det_val;
      dovf_q[0] <= det_ovf;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [DW:0] r2, rs;
    logic        ge;
    assign r2 = {r_q[s], n_q[s][QB-1]};
    assign ge = r2 >= {1'b0, d_q[s]};
    assign rs = ge ? r2 - {1'b0, d_q[s]} : r2;

    always_ff @(posedge clk_i) begin
      if (en) begin
        r_q[s+1]    <= rs[DW-1:0];
        n_q[s+1]    <= n_q[s] << 1;
        qb_q[s+1]   <= {qb_q[s][QB-2:0], ge};
        d_q[s+1]    <= d_q[s];
        neg_q[s+1]  <= neg_q[s];
        sat_q[s+1]  <= sat_q[s];
        sing_q[s+1] <= sing_q[s];
        last_q[s+1] <= last_q[s];
        kk_q[s+1]   <= kk_q[s];
        dv_q[s+1]   <= dv_q[s];
        dovf_q[s+1] <= dovf_q[s];
      end
    end
  end

  // result assembly
  logic [QB-1:0] qm, qlim;
  logic [W-1:0]  eval;
  logic          eovf, exit_v;
  logic [W-1:0]  asm_q [9];
  logic          acc_ovf_q, acc_prev;
  logic [W-1:0]  out_elem_q [9];
  logic [W-1:0]  out_det_q;
  logic          out_sing_q, out_ovf_q;

  always_comb begin
    qm   = qb_q[QB];
    qlim = QB'(1) << (W - 1);
    eovf = 1'b0;
    if (sing_q[QB]) begin
      eval = '0;
    end else if (sat_q[QB]) begin
      eval = neg_q[QB] ? VMIN : VMAX;
      eovf = 1'b1;
    end else if (!neg_q[QB] && qm >= qlim) begin
      eval = VMAX;
      eovf = 1'b1;
    end else if (neg_q[QB] && qm > qlim) begin
      eval = VMIN;
      eovf = 1'b1;
    end else begin
      eval = neg_q[QB] ? -qm[W-1:0] : qm[W-1:0];
    end
    acc_prev = (kk_q[QB] == mi3_pkg::FIRST_IDX) ? 1'b0 : acc_ovf_q;
    exit_v   = pv_q[QB] && en;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (exit_v && last_q[QB]) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exit_v) begin
      asm_q[kk_q[QB]] <= eval;
      acc_ovf_q       <= acc_prev | eovf;
      if (last_q[QB]) begin
        for (int j = 0; j < 8; j++) begin
          out_elem_q[j] <= asm_q[j];
        end
        out_elem_q[8] <= eval;
        out_det_q     <= dv_q[QB];
        out_sing_q    <= sing_q[QB];
        out_ovf_q     <= !sing_q[QB] && (acc_prev | eovf | dovf_q[QB]);
      end
    end
  end

  assign m_valid_o  = out_valid_q;
  assign det_o      = out_det_q;
  assign singular_o = out_sing_q;
  assign overflow_o = out_ovf_q;

  for (genvar g = 0; g < 9; g++) begin : g_out
    assign elem_o[g*W +: W] = out_elem_q[g];
  end

  a_sing_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sing_q) |-> (!out_ovf_q && out_det_q == '0))
    else $error("singular result with nonzero det or overflow");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pv_q[QB] && last_q[QB]) |-> (kk_q[QB] == mi3_pkg::LAST_IDX))
    else $error("last quotient with wrong element index");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> q_valid_i)
    else $error("queue popped while empty");

  a_pipe_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_ready_i) |=> ($stable(pv_q[QB]) && $stable(kk_q[QB])))
    else $error("divider advanced while output stalled");

endmodule

@@ src/matrix3x3_inverse_core.sv @@
// 3x3 matrix inverse by adjugate, signed fixed point (Q16.16 by default).
// Input channel s_axis: one item is a whole matrix, a11..a33 row by row.
// Output channel m_axis: one item per matrix, inv11..inv33 then det_value,
// with singular and overflow in tuser.
// The matrix rate is set by the front end, which takes a new matrix only
// after pushing the last one and works through the nine cofactors and
// three determinant terms on two pairs of multipliers. The back end feeds
// the nine quotients into a pipelined divider of ELEM_WIDTH+2 stages, one
// per cycle unless the output stalls.
// A two-entry queue sits between front and back, so the front takes a new
// matrix while the back still divides the previous ones.
// Reset clears all valid state; no items are in flight afterwards.
// A stalled receiver freezes the divider pipe and the output register; the
// queue then fills and s_axis_tready drops once the front end holds an item.
module matrix3x3_inverse_core #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // a11, a12, a13, a21, a22, a23, a31, a32, a33
  input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0]           s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // inv11, inv12, inv13, inv21, inv22, inv23, inv31, inv32, inv33, det_value
  output logic [((10*ELEM_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
  // singular, overflow
  output logic [1:0]                                  m_axis_tuser
);

  localparam int W      = ELEM_WIDTH;
  localparam int CW     = 2 * W + 1;
  localparam int DW     = 3 * W + 2;
  localparam int QW     = 9 * CW + DW;
  localparam int OUT_TW = ((10 * W + 7) / 8) * 8;

  logic          push, full, q_valid, pop;
  logic [9*CW-1:0] cof;
  logic [DW-1:0]   det;
  logic [QW-1:0]   q_data;
  logic [9*W-1:0]  elem;
  logic [W-1:0]    det_val;
  logic            singular, overflow;

  mi3_front #(
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata[9*W-1:0]),
    .push_o     (push),
    .full_i     (full),
    .cof_o      (cof),
    .det_o      (det)
  );

  mi3_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({det, cof}),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (q_data)
  );

  mi3_back #(
    .ELEM_WIDTH(ELEM_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .pop_o      (pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .elem_o     (elem),
    .det_o      (det_val),
    .singular_o (singular),
    .overflow_o (overflow)
  );

  assign m_axis_tdata = OUT_TW'({det_val, elem});
  assign m_axis_tuser = {overflow, singular};

endmodule

@@ dv/tb_matrix3x3_inverse_core.sv @@
`timescale 1ns / 100ps

class inverse_scoreboard;
  typedef struct {
    logic [319:0] data;
    logic [1:0]   flags;
  } inv_result_t;

  inv_result_t pending[$];
  int          n_errors;

  function new();
    n_errors = 0;
  endfunction

  static function logic signed [31:0] sat_q(logic signed [255:0] v, ref bit ovf);
    if (v > 256'sh7fffffff) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -256'sh80000000) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // truncating signed division on magnitudes
  static function logic signed [255:0] div_trunc(logic signed [255:0] n,
                                                 logic signed [255:0] d);
    logic [255:0] q;
    q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
    return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
  endfunction

  function void note_matrix(logic [287:0] m);
    logic signed [255:0] a [9];
    logic signed [255:0] cof [9];
    logic signed [255:0] det;
    inv_result_t r;
    bit ovf;
    for (int i = 0; i < 9; i++) a[i] = $signed(m[32*i +: 32]);
    cof[0] = a[4]*a[8] - a[7]*a[5];
    cof[1] = a[2]*a[7] - a[1]*a[8];
    cof[2] = a[1]*a[5] - a[2]*a[4];
    cof[3] = a[5]*a[6] - a[3]*a[8];
    cof[4] = a[0]*a[8] - a[2]*a[6];
    cof[5] = a[3]*a[2] - a[0]*a[5];
    cof[6] = a[3]*a[7] - a[6]*a[4];
    cof[7] = a[6]*a[1] - a[0]*a[7];
    cof[8] = a[0]*a[4] - a[3]*a[1];
    det = a[0]*cof[0] + a[1]*cof[3] + a[2]*cof[6];
    r.data = '0;
    ovf = 1'b0;
    if (det == 0) begin
      r.flags = 2'b01;
    end else begin
      for (int i = 0; i < 9; i++)
        r.data[32*i +: 32] = sat_q(div_trunc(cof[i] <<< 32, det), ovf);
      r.data[288 +: 32] = sat_q(div_trunc(det, 256'sd1 <<< 32), ovf);
      r.flags = {ovf, 1'b0};
    end
    pending.push_back(r);
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] exp_v);
    $display("ERROR %0t: %s got %h want %h", $time, what, got, exp_v);
    n_errors++;
  endtask

  task check_result(logic [319:0] data, logic [1:0] flags);
    inv_result_t e;
    if (pending.size() == 0) begin
      report("unexpected item", data[63:0], 0);
      return;
    end
    e = pending.pop_front();
    for (int i = 0; i < 10; i++)
      if (data[32*i +: 32] !== e.data[32*i +: 32])
        report($sformatf("field %0d", i), data[32*i +: 32], e.data[32*i +: 32]);
    if (flags[0] !== e.flags[0]) report("singular", flags[0], e.flags[0]);
    if (flags[1] !== e.flags[1]) report("overflow", flags[1], e.flags[1]);
  endtask
endclass

module tb_matrix3x3_inverse_core;
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [319:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  int src_idle_pct;
  int sink_idle_pct;
  inverse_scoreboard inv_sb = new();

  matrix3x3_inverse_core u_top (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) inv_sb.note_matrix(s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) inv_sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return {{24{1'($urandom_range(1))}}, 8'($urandom)};
      3: return $urandom_range(1) ? 32'h80000000 : 32'h7fffffff;
      4: return 32'($signed($urandom_range(0, 512)) - 256);
      default: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
    endcase
  endfunction

  task automatic send_matrix(logic [287:0] m);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= m;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random(int n);
    logic [287:0] m;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 9; i++) m[32*i +: 32] = rand_elem();
      // sometimes copy an element, or copy a row to force a singular matrix
      if ($urandom_range(9) == 0) m[64 +: 32] = m[0 +: 32];
      if ($urandom_range(9) == 0) m[96 +: 96] = m[0 +: 96];
      send_matrix(m);
    end
  endtask

  function automatic logic [287:0] diag(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
    logic [287:0] m;
    m = '0;
    m[0 +: 32] = d0;
    m[128 +: 32] = d1;
    m[256 +: 32] = d2;
    return m;
  endfunction

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    src_idle_pct = 0;
    sink_idle_pct = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    send_matrix(diag(32'h00010000, 32'h00010000, 32'h00010000));
    send_matrix(diag(32'h00020000, 32'hfffe0000, 32'h00008000));
    send_matrix('0);
    send_matrix({9{32'h00010000}});
    send_matrix(diag(32'h00000001, 32'h00000001, 32'h00000001));
    send_matrix(diag(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_matrix(diag(32'h80000000, 32'h80000000, 32'h80000000));
    send_matrix({9{32'h80000000}});
    send_matrix({32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                 32'h7fffffff, 32'h00000001, 32'h80000000, 32'hffffffff, 32'h7fffffff});
    send_matrix({9{32'hffffffff}});
    send_matrix(diag(32'h01000000, 32'h01000000, 32'h00000100));
    send_matrix({32'h00030000, 32'h00020000, 32'h00010000, 32'hffff0000,
                 32'h00040000, 32'h00050000, 32'h00020000, 32'hfffd0000, 32'h00010000});
    s_axis_tvalid <= 1'b0;
    // hold off until the pipeline has drained
    while (inv_sb.pending.size() != 0) @(negedge clk_i);
    src_idle_pct = 24; sink_idle_pct = 57;
    send_random(130);
    src_idle_pct = 57; sink_idle_pct = 24;
    send_random(130);
    src_idle_pct = 0; sink_idle_pct = 0;
    send_random(130);
    s_axis_tvalid <= 1'b0;
    while (inv_sb.pending.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    if (inv_sb.n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ matrix3x3_inverse_core.f @@
src/mi3_pkg.sv
src/mi3_queue.sv
src/mi3_front.sv
src/mi3_back.sv
src/matrix3x3_inverse_core.sv
dv/tb_matrix3x3_inverse_core.sv
